### rtl/acctilt_pkg.sv
// Package for the accelerometer tilt angle core: widths, flag struct,
// CORDIC arctangent table and the output scale constants. No dependencies.
package acctilt_pkg;

    localparam int SampleBits  = 13;
    localparam int CordicSteps = 20;
    localparam int AccelW      = 13;
    localparam int ModeW       = 2;
    localparam int TiltW       = 11;
    localparam int FracSqrt    = 12;
    localparam int SumW        = 2 * SampleBits;
    localparam int RootW       = SampleBits + FracSqrt;
    localparam int RadW        = 2 * RootW;
    localparam int CordW       = RootW + 3;
    localparam int AngW        = 33;
    localparam int AngMagW     = 32;
    localparam int RecipShift  = 40;
    localparam longint TiltNum   = 90000;
    localparam longint TiltDen   = 157;
    localparam longint TiltRecip = (TiltNum * 1024) / TiltDen;
    localparam int RightAngle  = 900;

    localparam logic [ModeW-1:0] ModeZ = 2'd0;
    localparam logic [ModeW-1:0] ModeX = 2'd1;
    localparam logic [ModeW-1:0] ModeY = 2'd2;

    typedef struct packed {
        logic neg;
        logic zero_num;
        logic zero_den;
        logic mode_bad;
    } t_flags;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/acctilt_front.sv
// Front stage: sign extension, squares of the two root axes, plain operand.
// Depends on acctilt_pkg.
module acctilt_front
    import acctilt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [AccelW-1:0]        i_x,
    input  logic [AccelW-1:0]        i_y,
    input  logic [AccelW-1:0]        i_z,
    input  logic [ModeW-1:0]         i_mode,
    output logic                     o_valid,
    output logic [SumW-1:0]          o_sum,
    output logic [RootW-1:0]         o_plain,
    output logic                     o_num_is_root,
    output t_flags                   o_flags
);
    logic [AccelW+SampleBits-1:0] ext_x, ext_y, ext_z;
    logic signed [SampleBits-1:0] sx, sy, sz, sa, sb, sp;
    logic signed [SumW-1:0]       sq_a, sq_b;
    logic [SampleBits-1:0]        pmag;
    logic [SumW-1:0]              n_sum;
    t_flags                       n_flags;
    logic                         r_valid;

    assign ext_x = {{SampleBits{1'b0}}, i_x};
    assign ext_y = {{SampleBits{1'b0}}, i_y};
    assign ext_z = {{SampleBits{1'b0}}, i_z};
    assign sx = signed'(ext_x[SampleBits-1:0]);
    assign sy = signed'(ext_y[SampleBits-1:0]);
    assign sz = signed'(ext_z[SampleBits-1:0]);

    always_comb begin
        unique case (i_mode)
            ModeX: begin
                sa = sy; sb = sz; sp = sx;
            end
            ModeY: begin
                sa = sx; sb = sz; sp = sy;
            end
            default: begin
                sa = sx; sb = sy; sp = sz;
            end
        endcase
        sq_a  = sa * sa;
        sq_b  = sb * sb;
        n_sum = SumW'(sq_a) + SumW'(sq_b);
        pmag  = sp[SampleBits-1] ? SampleBits'(-sp) : SampleBits'(sp);
        n_flags.neg      = sp[SampleBits-1];
        n_flags.mode_bad = (i_mode != ModeZ) && (i_mode != ModeX) && (i_mode != ModeY);
        if (i_mode == ModeZ) begin
            n_flags.zero_num = (n_sum == '0);
            n_flags.zero_den = (pmag == '0);
        end else begin
            n_flags.zero_num = (pmag == '0);
            n_flags.zero_den = (n_sum == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            o_sum         <= n_sum;
            o_plain       <= {pmag, {FracSqrt{1'b0}}};
            o_num_is_root <= (i_mode == ModeZ);
            o_flags       <= n_flags;
        end
    end

    assign o_valid = r_valid;
endmodule

### rtl/acctilt_sqrt.sv
// Pipelined floor square root of sum * 2^24, one root bit per stage.
// Carries the plain operand and flags alongside. Depends on acctilt_pkg.
module acctilt_sqrt
    import acctilt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SumW-1:0]     i_sum,
    input  logic [RootW-1:0]    i_plain,
    input  logic                i_num_is_root,
    input  t_flags              i_flags,
    output logic                o_valid,
    output logic [RootW-1:0]    o_num,
    output logic [RootW-1:0]    o_den,
    output t_flags              o_flags
);
    localparam int RemW = RootW + 2;

    logic [RootW:0]      r_valid;
    logic [RemW-1:0]     r_rem  [RootW+1];
    logic [RootW-1:0]    r_root [RootW+1];
    logic [RadW-1:0]     r_rad  [RootW+1];
    logic [RootW-1:0]    r_plain[RootW+1];
    logic [RootW:0]      r_nroot;
    t_flags              r_flags[RootW+1];

    always_comb begin
        r_valid[0] = i_valid;
        r_rem[0]   = '0;
        r_root[0]  = '0;
        r_rad[0]   = {i_sum, {(RadW-SumW){1'b0}}};
        r_plain[0] = i_plain;
        r_nroot[0] = i_num_is_root;
        r_flags[0] = i_flags;
    end

    for (genvar j = 0; j < RootW; j++) begin : g_step
        logic [RemW-1:0] n_rem, trial;
        always_comb begin
            n_rem = {r_rem[j][RemW-3:0], r_rad[j][RadW-1 -: 2]};
            trial = {r_root[j], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= r_valid[j];
            end
            if (i_en) begin
                if (n_rem >= trial) begin
                    r_rem[j+1]  <= n_rem - trial;
                    r_root[j+1] <= {r_root[j][RootW-2:0], 1'b1};
                end else begin
                    r_rem[j+1]  <= n_rem;
                    r_root[j+1] <= {r_root[j][RootW-2:0], 1'b0};
                end
                r_rad[j+1]   <= {r_rad[j][RadW-3:0], 2'b00};
                r_plain[j+1] <= r_plain[j];
                r_nroot[j+1] <= r_nroot[j];
                r_flags[j+1] <= r_flags[j];
            end
        end
    end

    assign o_valid = r_valid[RootW];
    assign o_num   = r_nroot[RootW] ? r_root[RootW] : r_plain[RootW];
    assign o_den   = r_nroot[RootW] ? r_plain[RootW] : r_root[RootW];
    assign o_flags = r_flags[RootW];
endmodule

### rtl/acctilt_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage, Q30 angle.
// Depends on acctilt_pkg.
module acctilt_cordic
    import acctilt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [RootW-1:0]        i_num,
    input  logic [RootW-1:0]        i_den,
    input  t_flags                  i_flags,
    output logic                    o_valid,
    output logic signed [AngW-1:0]  o_angle,
    output t_flags                  o_flags
);
    logic [CordicSteps:0]      r_valid;
    logic signed [CordW-1:0]   r_xv [CordicSteps+1];
    logic signed [CordW-1:0]   r_yv [CordicSteps+1];
    logic signed [AngW-1:0]    r_acc[CordicSteps+1];
    t_flags                    r_flags[CordicSteps+1];

    always_comb begin
        r_valid[0] = i_valid;
        r_xv[0]    = signed'(CordW'(i_den));
        r_yv[0]    = signed'(CordW'(i_num));
        r_acc[0]   = '0;
        r_flags[0] = i_flags;
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
        logic signed [CordW-1:0] dx, dy;
        logic signed [AngW-1:0]  ang;
        always_comb begin
            dx  = r_yv[i] >>> i;
            dy  = r_xv[i] >>> i;
            ang = signed'({1'b0, atan_q30(i)});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
            if (i_en) begin
                if (r_yv[i] > 0) begin
                    r_xv[i+1]  <= r_xv[i] + dx;
                    r_yv[i+1]  <= r_yv[i] - dy;
                    r_acc[i+1] <= r_acc[i] + ang;
                end else begin
                    r_xv[i+1]  <= r_xv[i] - dx;
                    r_yv[i+1]  <= r_yv[i] + dy;
                    r_acc[i+1] <= r_acc[i] - ang;
                end
                r_flags[i+1] <= r_flags[i];
            end
        end
    end

    assign o_valid = r_valid[CordicSteps];
    assign o_angle = r_acc[CordicSteps];
    assign o_flags = r_flags[CordicSteps];
endmodule

### rtl/acctilt_scale.sv
// Angle to tenths of a degree: reciprocal multiply, one-step correction,
// clamp, special cases and sign. Two register stages. Depends on acctilt_pkg.
module acctilt_scale
    import acctilt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [AngW-1:0]  i_angle,
    input  t_flags                  i_flags,
    output logic                    o_valid,
    output logic signed [TiltW-1:0] o_tilt
);
    localparam int ProdW = AngMagW + 17;
    localparam int EstW  = AngMagW + 20;
    localparam int QW    = EstW - RecipShift;

    logic [AngMagW-1:0] amag;
    logic [ProdW-1:0]   r_prod;
    logic [EstW-1:0]    r_est;
    t_flags             r_flags;
    logic               r_valid1, r_valid2;
    logic [QW-1:0]      q0, q;
    logic [QW+7:0]      bound;
    logic [TiltW-1:0]   mag_t;
    logic signed [TiltW-1:0] n_tilt;

    // angle is never negative in range; clamp anyway
    assign amag = i_angle[AngW-1] ? '0 : i_angle[AngMagW-1:0];

    always_comb begin
        q0    = r_est[EstW-1 -: QW];
        bound = (QW+8)'(q0 + 1'b1) * (QW+8)'(TiltDen);
        // estimate is low by at most one
        q     = ({bound, 30'b0} <= (QW+38)'(r_prod)) ? q0 + 1'b1 : q0;
        if (q > QW'(RightAngle)) begin
            mag_t = TiltW'(RightAngle);
        end else begin
            mag_t = TiltW'(q);
        end
        if (r_flags.mode_bad || r_flags.zero_num) begin
            mag_t = '0;
        end else if (r_flags.zero_den) begin
            mag_t = TiltW'(RightAngle);
        end
        n_tilt = r_flags.neg ? -signed'(mag_t) : signed'(mag_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
        if (i_en) begin
            r_prod  <= ProdW'(amag) * ProdW'(TiltNum);
            r_est   <= EstW'(amag) * EstW'(TiltRecip);
            r_flags <= i_flags;
            o_tilt  <= n_tilt;
        end
    end

    assign o_valid = r_valid2;
endmodule

### rtl/accel_tilt_angle_core.sv
// Top level of the accelerometer tilt angle core: front, square root,
// CORDIC and scale pipelines. Depends on acctilt_pkg and the acctilt_* modules.
//
// channel  dir  tdata                               tuser
// s_axis   in   [12:0] x, [25:13] y, [38:26] z      [1:0] mode (0 Z, 1 X, 2 Y)
// m_axis   out  [10:0] tilt_tenths (signed)         -
//
// The square-root pipeline yields one root bit per stage, the CORDIC one
// rotation per stage. One request is taken every cycle unless held: the
// whole pipeline holds while a result waits on m_axis; s_axis tready
// follows that. Reset clears only valid bits.
module accel_tilt_angle_core
    import acctilt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // x[12:0], y[25:13], z[38:26], pad
    input  logic [1:0]  i_s_axis_tuser,   // mode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // tilt_tenths[10:0], pad
);
    logic en;
    logic f_valid, f_nroot, q_valid, c_valid, o_valid;
    logic [SumW-1:0]  f_sum;
    logic [RootW-1:0] f_plain, q_num, q_den;
    t_flags           f_flags, q_flags, c_flags;
    logic signed [AngW-1:0]  c_angle;
    logic signed [TiltW-1:0] tilt;

    assign en = !o_valid || i_m_axis_tready;

    acctilt_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_s_axis_tvalid),
        .i_x(i_s_axis_tdata[12:0]), .i_y(i_s_axis_tdata[25:13]),
        .i_z(i_s_axis_tdata[38:26]), .i_mode(i_s_axis_tuser),
        .o_valid(f_valid), .o_sum(f_sum), .o_plain(f_plain),
        .o_num_is_root(f_nroot), .o_flags(f_flags)
    );

    acctilt_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(f_valid), .i_sum(f_sum),
        .i_plain(f_plain), .i_num_is_root(f_nroot), .i_flags(f_flags),
        .o_valid(q_valid), .o_num(q_num), .o_den(q_den), .o_flags(q_flags)
    );

    acctilt_cordic u_cordic (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(q_valid), .i_num(q_num),
        .i_den(q_den), .i_flags(q_flags),
        .o_valid(c_valid), .o_angle(c_angle), .o_flags(c_flags)
    );

    acctilt_scale u_scale (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(c_valid), .i_angle(c_angle),
        .i_flags(c_flags), .o_valid(o_valid), .o_tilt(tilt)
    );

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = o_valid;
    assign o_m_axis_tdata  = {5'b0, tilt};

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (tilt <= 11'sd900 && tilt >= -11'sd900))
        else $error("tilt out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_m_axis_tready) |=> (o_valid && $stable(tilt)))
        else $error("waiting result lost");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(c_valid) && $stable(q_valid) && $stable(f_valid)))
        else $error("pipeline moved while stalled");
endmodule
